@@ src/flash_log_end_search_assert.svh @@
// ---------------------------------------------------------------------------
// Flash log end search assertion macros
// Assertion macros shared by the checker files of the flash log end search block.
// ---------------------------------------------------------------------------
`ifndef FLASH_LOG_END_SEARCH_ASSERT_SVH
`define FLASH_LOG_END_SEARCH_ASSERT_SVH

// Same-cycle implication, with a disable condition.
`define FLES_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, with a disable condition.
`define FLES_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/fles_pkg.sv @@
// ---------------------------------------------------------------------------
// Flash log end search package
// Codes, widths and shared types of the flash log end search block.
// ---------------------------------------------------------------------------
package fles_pkg;

   localparam int INDEX_W = 16;
   localparam int COUNT_W = 17;
   localparam int ADDR_W  = 24;
   localparam int END_W   = 25;
   localparam int BYTE_W  = 8;

   localparam int                PACKET_BYTES_DEFAULT = 32;
   localparam logic [COUNT_W-1:0] PACKET_COUNT_RESET  = 17'd1024;
   localparam logic [BYTE_W-1:0]  ERASED_BYTE         = 8'hFF;

   localparam logic OP_START    = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_FIRST = 3'd1;
   localparam logic [2:0] PH_MID   = 3'd2;
   localparam logic [2:0] PH_LOOP  = 3'd3;
   localparam logic [2:0] PH_FINAL = 3'd4;

   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_FAIL   = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   typedef struct packed {
      logic [2:0]         phase;
      logic [INDEX_W-1:0] lower_bound;
      logic [INDEX_W-1:0] upper_bound;
      logic [INDEX_W-1:0] probe_index;
   } search_state_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [ADDR_W-1:0] read_address;
      logic [END_W-1:0]  data_end;
   } search_result_type;

endpackage

@@ src/fles_step.sv @@
// ---------------------------------------------------------------------------
// Flash log end search step
// Combinational decision for one request: next search state and the result.
// ---------------------------------------------------------------------------
module fles_step import fles_pkg::*; #(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic                opcode,
   input  logic [BYTE_W-1:0]   read_byte,
   input  logic                read_ok,
   input  logic [COUNT_W-1:0]  packet_count,
   input  search_state_type    cur,
   output search_state_type    nxt,
   output search_result_type   result
);

   localparam logic [8:0] PB = 9'(PACKET_BYTES);

   logic               erased;
   logic [INDEX_W-1:0] lo_s;
   logic [INDEX_W-1:0] up_s;
   logic [COUNT_W-1:0] bound_sum;
   logic [INDEX_W-1:0] mid;
   logic               last_probe;
   logic [COUNT_W-1:0] end_index;
   logic [END_W:0]     end_prod;
   logic [END_W-1:0]   addr_prod;
   logic [1:0]         kind;

   assign erased = (read_byte == ERASED_BYTE);

   always_comb begin
      lo_s = cur.lower_bound;
      up_s = cur.upper_bound;
      if (cur.phase == PH_MID) begin
         lo_s = INDEX_W'(1);
         up_s = cur.probe_index;
      end else if (erased) begin
         up_s = cur.probe_index;
      end else begin
         lo_s = cur.probe_index;
      end
   end

   assign bound_sum  = {1'b0, up_s} + {1'b0, lo_s};
   assign mid        = bound_sum[COUNT_W-1:1];
   assign last_probe = ({1'b0, up_s} <= ({1'b0, lo_s} + COUNT_W'(1)));

   always_comb begin
      nxt       = cur;
      kind      = KIND_REJECT;
      end_index = '0;
      if (opcode == OP_START) begin
         if (cur.phase == PH_IDLE) begin
            kind            = KIND_READ;
            nxt.probe_index = '0;
            nxt.phase       = PH_FIRST;
         end
      end else if (cur.phase != PH_IDLE && cur.phase <= PH_FINAL) begin
         if (!read_ok) begin
            kind      = KIND_FAIL;
            nxt.phase = PH_IDLE;
         end else begin
            unique case (cur.phase) inside
               PH_FIRST: begin
                  if (erased) begin
                     kind      = KIND_END;
                     nxt.phase = PH_IDLE;
                  end else begin
                     kind            = KIND_READ;
                     nxt.probe_index = packet_count[COUNT_W-1:1];
                     nxt.phase       = PH_MID;
                  end
               end
               PH_MID, PH_LOOP: begin
                  if (cur.phase == PH_MID && !erased) begin
                     kind      = KIND_END;
                     end_index = {1'b0, cur.probe_index};
                     nxt.phase = PH_IDLE;
                  end else begin
                     kind            = KIND_READ;
                     nxt.lower_bound = lo_s;
                     nxt.upper_bound = up_s;
                     nxt.probe_index = mid;
                     nxt.phase       = last_probe ? PH_FINAL : PH_LOOP;
                  end
               end
               default: begin
                  kind      = KIND_END;
                  nxt.phase = PH_IDLE;
                  end_index = erased ? {1'b0, cur.probe_index}
                                     : {1'b0, cur.probe_index} + COUNT_W'(1);
               end
            endcase
         end
      end
   end

   assign end_prod  = (END_W+1)'(end_index) * (END_W+1)'(PB);
   assign addr_prod = END_W'(nxt.probe_index) * END_W'(PB);

   always_comb begin
      result.result_kind  = kind;
      result.read_address = (kind == KIND_READ) ? addr_prod[ADDR_W-1:0] : '0;
      result.data_end     = (kind == KIND_END) ? end_prod[END_W-1:0] : '0;
   end

endmodule

@@ src/flash_log_end_search.sv @@
// ---------------------------------------------------------------------------
// Flash log end search
// Binary search for the first erased packet slot of an append-only flash log.
// ---------------------------------------------------------------------------
//  Channel  Prefix  Direction  Carries
//  request  req_    in         opcode, read_byte, read_ok
//  result   rsp_    out        result_kind, read_address, data_end
//  config   csr_    in         packet_count
//
// One request is taken per cycle while the result is not stalled; each
// request gives exactly one result. A taken request lands in the input
// register, and the step logic then fills the result register once the
// result channel is free.
// Synchronous reset clears the search to idle and packet_count to 1024.
// A stalled result holds the result register, which holds the input register.
// Configuration writes are taken in every cycle.
module flash_log_end_search import fles_pkg::*; #(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [BYTE_W-1:0]  req_read_byte,
   input  logic               req_read_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic [ADDR_W-1:0]  rsp_read_address,
   output logic [END_W-1:0]   rsp_data_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_packet_count
);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic               opcode_ff;
   logic [BYTE_W-1:0]  read_byte_ff;
   logic               read_ok_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   search_result_type  result_ff;
   search_result_type  result_in;
   search_state_type   state_ff;
   search_state_type   state_in;
   logic [COUNT_W-1:0] packet_count_ff;
   logic               advance;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign csr_ready   = 1'b1;

   fles_step #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_step (
      .opcode       (opcode_ff),
      .read_byte    (read_byte_ff),
      .read_ok      (read_ok_ff),
      .packet_count (packet_count_ff),
      .cur          (state_ff),
      .nxt          (state_in),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         state_ff        <= '{phase: PH_IDLE, default: '0};
         packet_count_ff <= PACKET_COUNT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            packet_count_ff <= csr_packet_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         opcode_ff    <= req_opcode;
         read_byte_ff <= req_read_byte;
         read_ok_ff   <= req_read_ok;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = result_ff.result_kind;
   assign rsp_read_address = result_ff.read_address;
   assign rsp_data_end     = result_ff.data_end;

endmodule

@@ src/fles_checker.sv @@
// ---------------------------------------------------------------------------
// Flash log end search checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "flash_log_end_search_assert.svh"

module fles_checker import fles_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_result_kind,
   input logic [ADDR_W-1:0]  rsp_read_address,
   input logic [END_W-1:0]   rsp_data_end
);

   `FLES_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "result valid after reset")
   `FLES_ASSERT_IMP(a_addr_only_read, clock, reset, rsp_valid && rsp_result_kind != KIND_READ, rsp_read_address == '0, "address on non-read result")
   `FLES_ASSERT_IMP(a_end_only_found, clock, reset, rsp_valid && rsp_result_kind != KIND_END, rsp_data_end == '0, "end offset on non-end result")
   `FLES_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_data_end), "stalled result changed")
   `FLES_ASSERT_NEXT(a_idle_no_result, clock, reset, !rsp_valid && !(req_valid && req_ready), !rsp_valid || $past(req_ready), "result without request")

endmodule

bind flash_log_end_search fles_checker u_fles_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_read_address (rsp_read_address),
   .rsp_data_end     (rsp_data_end)
);

@@ dv/flash_log_end_search_tb.sv @@
// ---------------------------------------------------------------------------
// Flash log end search testbench
// Drives start commands and flash read responses into the search block,
// predicts every result from its own copy of the search state, and checks
// each result in order. Gaps and result stalls come in random bursts.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module flash_log_end_search_tb import fles_pkg::*; ();

   localparam int PACKET_BYTES = PACKET_BYTES_DEFAULT;
   localparam int ITEM_COUNT   = 1800;
   localparam int CALM_FROM    = 1600;

   class end_search_scoreboard;
      logic [COUNT_W-1:0] slots;
      logic [2:0]         step;
      logic [INDEX_W-1:0] low_mark;
      logic [INDEX_W-1:0] high_mark;
      logic [INDEX_W-1:0] probe;
      search_result_type  awaited[$];
      int                 errors;

      function new();
         slots     = PACKET_COUNT_RESET;
         step      = PH_IDLE;
         low_mark  = '0;
         high_mark = '0;
         probe     = '0;
         errors    = 0;
      endfunction

      function search_result_type ask_probe(logic [INDEX_W-1:0] index, logic [2:0] next_step);
         search_result_type r;
         probe = index;
         step  = next_step;
         r = '0;
         r.result_kind  = KIND_READ;
         r.read_address = ADDR_W'(int'(index) * PACKET_BYTES);
         return r;
      endfunction

      function search_result_type found_end(int offset);
         search_result_type r;
         step = PH_IDLE;
         r = '0;
         r.result_kind = KIND_END;
         r.data_end    = END_W'(offset);
         return r;
      endfunction

      function search_result_type narrow();
         int lo;
         int hi;
         lo = low_mark;
         hi = high_mark;
         if (hi <= lo + 1) begin
            return ask_probe(INDEX_W'((hi + lo) >> 1), PH_FINAL);
         end
         return ask_probe(INDEX_W'((hi + lo) >> 1), PH_LOOP);
      endfunction

      function void note_request(logic op, logic [BYTE_W-1:0] rbyte, logic ok);
         search_result_type r;
         logic              erased;
         erased = (rbyte == ERASED_BYTE);
         r = '0;
         r.result_kind = KIND_REJECT;
         if (op == OP_START) begin
            if (step == PH_IDLE) begin
               r = ask_probe('0, PH_FIRST);
            end
         end else if (step != PH_IDLE && step <= PH_FINAL) begin
            if (!ok) begin
               step = PH_IDLE;
               r.result_kind = KIND_FAIL;
            end else begin
               case (step)
                  PH_FIRST: begin
                     if (erased) begin
                        r = found_end(0);
                     end else begin
                        r = ask_probe(INDEX_W'(slots >> 1), PH_MID);
                     end
                  end
                  PH_MID: begin
                     if (!erased) begin
                        r = found_end(int'(probe) * PACKET_BYTES);
                     end else begin
                        low_mark  = INDEX_W'(1);
                        high_mark = probe;
                        r = narrow();
                     end
                  end
                  PH_LOOP: begin
                     if (erased) begin
                        high_mark = probe;
                     end else begin
                        low_mark = probe;
                     end
                     r = narrow();
                  end
                  default: begin
                     if (erased) begin
                        r = found_end(int'(probe) * PACKET_BYTES);
                     end else begin
                        r = found_end((int'(probe) + 1) * PACKET_BYTES);
                     end
                  end
               endcase
            end
         end
         awaited.push_back(r);
      endfunction

      function void check_result(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                                 logic [END_W-1:0] offset);
         search_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result kind %0d address %0h end %0h",
                     $time, kind, addr, offset);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (kind !== want.result_kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time, want.result_kind, kind);
            errors++;
         end
         if (addr !== want.read_address) begin
            $display("%0t: read_address expected %0h actual %0h",
                     $time, want.read_address, addr);
            errors++;
         end
         if (offset !== want.data_end) begin
            $display("%0t: data_end expected %0h actual %0h", $time, want.data_end, offset);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_opcode;
   logic [BYTE_W-1:0]  req_read_byte;
   logic               req_read_ok;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_result_kind;
   logic [ADDR_W-1:0]  rsp_read_address;
   logic [END_W-1:0]   rsp_data_end;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_packet_count;

   end_search_scoreboard board;
   bit                   calm;
   int                   gap_pct;
   int                   stall_pct;
   int                   sent;

   flash_log_end_search #(.PACKET_BYTES(PACKET_BYTES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_read_byte(req_read_byte),
      .req_read_ok(req_read_ok),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_read_address(rsp_read_address),
      .rsp_data_end(rsp_data_end),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_packet_count(csr_packet_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_result_kind, rsp_read_address, rsp_data_end);
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_request(logic op, logic [BYTE_W-1:0] rbyte, logic ok);
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_read_byte <= rbyte;
      req_read_ok   <= ok;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, rbyte, ok);
      sent++;
      if (sent >= CALM_FROM) begin
         calm = 1'b1;
      end
   endtask

   task automatic write_count(logic [COUNT_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      csr_valid        <= 1'b1;
      csr_packet_count <= value;
      do @(posedge clock); while (!csr_ready);
      board.slots = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [COUNT_W-1:0] random_count();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return COUNT_W'(1);
               2: return COUNT_W'(2);
               3: return COUNT_W'(65536);
               default: return '1;
            endcase
         end
         1, 2: return COUNT_W'($urandom_range(2, 64));
         3: return COUNT_W'($urandom_range(2, 65536));
         4: return COUNT_W'($urandom_range(0, 131071));
         default: return PACKET_COUNT_RESET;
      endcase
   endfunction

   task automatic run_search();
      int log_end;
      int span;
      int pick;
      span = (board.slots < 2) ? 1 : int'(board.slots);
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
         log_end = 0;
      end else if (pick == 1) begin
         log_end = span;
      end else begin
         log_end = $urandom_range(0, span);
      end
      send_request(OP_START, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      while (board.step != PH_IDLE) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_request(OP_START, BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
         end else if (pick < 6) begin
            send_request(OP_RESPONSE, BYTE_W'($urandom_range(0, 255)), 1'b0);
         end else if (pick < 9) begin
            send_request(OP_RESPONSE, BYTE_W'($urandom_range(0, 255)), 1'b1);
         end else begin
            if (pick == 99) begin
               write_count(random_count());
            end
            if (int'(board.probe) < log_end) begin
               send_request(OP_RESPONSE, BYTE_W'($urandom_range(0, 254)), 1'b1);
            end else begin
               send_request(OP_RESPONSE, ERASED_BYTE, 1'b1);
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_START;
      req_read_byte    = '0;
      req_read_ok      = 1'b0;
      csr_valid        = 1'b0;
      csr_packet_count = '0;
      board            = new();
      calm             = 1'b0;
      gap_pct          = 0;
      stall_pct        = 0;
      sent             = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_request(OP_RESPONSE, ERASED_BYTE, 1'b1);
      send_request(OP_START, 8'h00, 1'b0);
      send_request(OP_START, ERASED_BYTE, 1'b1);
      send_request(OP_RESPONSE, ERASED_BYTE, 1'b1);
      send_request(OP_START, 8'hAA, 1'b1);
      send_request(OP_RESPONSE, 8'h00, 1'b1);
      send_request(OP_RESPONSE, 8'h00, 1'b1);
      send_request(OP_START, 8'h55, 1'b0);
      send_request(OP_RESPONSE, 8'h7E, 1'b0);
      send_request(OP_START, 8'h00, 1'b1);
      send_request(OP_RESPONSE, 8'hFE, 1'b1);
      send_request(OP_RESPONSE, ERASED_BYTE, 1'b1);
      send_request(OP_RESPONSE, 8'h01, 1'b0);
      send_request(OP_START, 8'h00, 1'b1);
      send_request(OP_RESPONSE, 8'h80, 1'b1);
      // A count written in the middle of a search must not disturb it.
      write_count(COUNT_W'(3));
      send_request(OP_RESPONSE, ERASED_BYTE, 1'b1);
      send_request(OP_RESPONSE, ERASED_BYTE, 1'b0);
      write_count('0);
      send_request(OP_START, 8'h00, 1'b1);
      send_request(OP_RESPONSE, 8'h7F, 1'b1);
      send_request(OP_RESPONSE, ERASED_BYTE, 1'b1);
      send_request(OP_RESPONSE, 8'h40, 1'b1);
      write_count(COUNT_W'(2));
      send_request(OP_START, 8'h00, 1'b1);
      send_request(OP_RESPONSE, 8'h10, 1'b1);
      send_request(OP_RESPONSE, ERASED_BYTE, 1'b1);
      send_request(OP_RESPONSE, ERASED_BYTE, 1'b1);

      while (sent < ITEM_COUNT) begin
         if ($urandom_range(0, 7) == 0) begin
            write_count(random_count());
         end
         if (!calm) begin
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
         end
         if ($urandom_range(0, 19) == 0) begin
            send_request(OP_RESPONSE, BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
         end
         run_search();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
